### rtl/ftlk_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the filtered three-LFSR keystream generator.
// No dependencies; all files but ftlk_in_if use it by scoped names.
package ftlk_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int SEED_W     = 16;
    localparam int FILT_W     = 8;
    localparam int SEL_W      = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_TAPS_ZERO    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAPS_ONE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAPS_TWO     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED_ZERO    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED_ONE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED_TWO     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_TABLE = 3'd6;

    // Step control broadcast along every register row.
    typedef struct packed {
        logic step;
        logic restart;
    } t_step_ctl;

endpackage

### rtl/ftlk_in_if.sv
`timescale 1ns / 1ps
// Input channel of the keystream generator: valid/ready plus restart and data bit.
// No dependencies.
interface ftlk_in_if;
    logic valid;
    logic ready;
    logic restart;
    logic data_bit;

    modport source (output valid, output restart, output data_bit, input ready);
    modport sink   (input valid, input restart, input data_bit, output ready);
endinterface

### rtl/ftlk_out_if.sv
`timescale 1ns / 1ps
// Output channel of the keystream generator: valid/ready plus result fields.
// Depends on ftlk_pkg for the filter select width.
interface ftlk_out_if;
    logic                          valid;
    logic                          ready;
    logic                          key_bit;
    logic                          mixed_bit;
    logic [ftlk_pkg::SEL_W-1:0]    register_bits;

    modport source (output valid, output key_bit, output mixed_bit, output register_bits,
                    input ready);
    modport sink   (input valid, input key_bit, input mixed_bit, input register_bits,
                    output ready);
endinterface

### rtl/ftlk_cell.sv
`timescale 1ns / 1ps
// One bit cell of an LFSR row: holds a state bit and takes its neighbor's bit on a step.
// Depends on ftlk_pkg for the step control struct.
module ftlk_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ftlk_pkg::t_step_ctl i_ctl,
    input  logic                i_seed,
    input  logic                i_tap,
    input  logic                i_from_up,
    output logic                o_bit,
    output logic                o_tapped
);
    logic r_bit;
    logic n_bit;

    // restart loads the seed ahead of the shift within the same transaction
    assign o_bit    = i_ctl.restart ? i_seed : r_bit;
    assign o_tapped = o_bit & i_tap;

    always_comb begin
        n_bit = r_bit;
        if (i_ctl.step) begin
            n_bit = i_from_up;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit <= 1'b0;
        end else begin
            r_bit <= n_bit;
        end
    end
endmodule

### rtl/ftlk_lfsr.sv
`timescale 1ns / 1ps
// One Fibonacci LFSR as a row of bit cells with parity feedback into the top cell.
// Depends on ftlk_pkg and ftlk_cell.
module ftlk_lfsr #(
    parameter int REG_LEN = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ftlk_pkg::t_step_ctl           i_ctl,
    input  logic [ftlk_pkg::SEED_W-1:0]   i_seed,
    input  logic [ftlk_pkg::SEED_W-1:0]   i_taps,
    output logic                          o_bit
);
    logic [REG_LEN-1:0] w_bit;
    logic [REG_LEN-1:0] w_tapped;
    logic               w_fb;

    // parity of the pre-shift state under the tap mask
    assign w_fb  = ^w_tapped;
    assign o_bit = w_bit[0];

    for (genvar i = 0; i < REG_LEN; i++) begin : g_cell
        logic w_seed;
        logic w_tap;
        logic w_up;

        // bits above the seed and tap width read as zero
        if (i < ftlk_pkg::SEED_W) begin : g_cfg
            assign w_seed = i_seed[i];
            assign w_tap  = i_taps[i];
        end else begin : g_zero
            assign w_seed = 1'b0;
            assign w_tap  = 1'b0;
        end

        if (i == REG_LEN - 1) begin : g_top
            assign w_up = w_fb;
        end else begin : g_mid
            assign w_up = w_bit[i+1];
        end

        ftlk_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (i_ctl),
            .i_seed    (w_seed),
            .i_tap     (w_tap),
            .i_from_up (w_up),
            .o_bit     (w_bit[i]),
            .o_tapped  (w_tapped[i])
        );
    end
endmodule

### rtl/filtered_three_lfsr_keystream.sv
`timescale 1ns / 1ps
// Top level: three LFSR cell rows, 8-entry filter and registered output stage.
// Depends on ftlk_pkg, ftlk_in_if, ftlk_out_if and ftlk_lfsr.
//
// Usage:
//   i_req carries one transaction per keystream bit: restart reloads all three
//   registers from their seeds before the step, data_bit is mixed with the key.
//   o_rsp returns key_bit, mixed_bit = data_bit ^ key_bit, and register_bits
//   (the three emitted LFSR bits, first register in bit 0).
//   Configuration writes go through i_cfg_we / i_cfg_idx / i_cfg_data: indexes
//   0..2 tap masks, 3..5 seeds, 6 filter table; index 7 is ignored. Write only
//   while no transaction is in flight.
//   An accepted transaction is registered in the output stage and shows on o_rsp
//   in the next cycle. Throughput is one transaction per cycle, set by the single
//   output register, while o_rsp.ready holds; each row shifts and forms parity in a step.
//   i_req.ready is high whenever the output register is empty or being taken,
//   so a stalled receiver holds the result and back-pressures the input.
//   Synchronous reset clears all three LFSR states, the configuration and the
//   output valid.
module filtered_three_lfsr_keystream #(
    parameter int REG_LEN = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [ftlk_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [ftlk_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    ftlk_in_if.sink                            i_req,
    ftlk_out_if.source                         o_rsp
);
    logic [ftlk_pkg::SEED_W-1:0] r_taps_zero, r_taps_one, r_taps_two;
    logic [ftlk_pkg::SEED_W-1:0] r_seed_zero, r_seed_one, r_seed_two;
    logic [ftlk_pkg::FILT_W-1:0] r_filter;

    logic                        r_out_valid;
    logic                        r_key;
    logic                        r_mixed;
    logic [ftlk_pkg::SEL_W-1:0]  r_sel;

    ftlk_pkg::t_step_ctl         w_ctl;
    logic                        w_accept;
    logic [ftlk_pkg::SEL_W-1:0]  w_sel;
    logic                        w_key;

    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_ctl.step    = w_accept;
    assign w_ctl.restart = w_accept && i_req.restart;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taps_zero <= '0;
            r_taps_one  <= '0;
            r_taps_two  <= '0;
            r_seed_zero <= '0;
            r_seed_one  <= '0;
            r_seed_two  <= '0;
            r_filter    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ftlk_pkg::CFG_TAPS_ZERO:    r_taps_zero <= i_cfg_data;
                ftlk_pkg::CFG_TAPS_ONE:     r_taps_one  <= i_cfg_data;
                ftlk_pkg::CFG_TAPS_TWO:     r_taps_two  <= i_cfg_data;
                ftlk_pkg::CFG_SEED_ZERO:    r_seed_zero <= i_cfg_data;
                ftlk_pkg::CFG_SEED_ONE:     r_seed_one  <= i_cfg_data;
                ftlk_pkg::CFG_SEED_TWO:     r_seed_two  <= i_cfg_data;
                ftlk_pkg::CFG_FILTER_TABLE: r_filter    <= i_cfg_data[ftlk_pkg::FILT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    ftlk_lfsr #(.REG_LEN(REG_LEN)) u_lfsr_zero (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_seed  (r_seed_zero),
        .i_taps  (r_taps_zero),
        .o_bit   (w_sel[0])
    );

    ftlk_lfsr #(.REG_LEN(REG_LEN)) u_lfsr_one (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_seed  (r_seed_one),
        .i_taps  (r_taps_one),
        .o_bit   (w_sel[1])
    );

    ftlk_lfsr #(.REG_LEN(REG_LEN)) u_lfsr_two (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_seed  (r_seed_two),
        .i_taps  (r_taps_two),
        .o_bit   (w_sel[2])
    );

    assign w_key = r_filter[w_sel];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_out_valid <= i_req.valid;
        end
    end

    // hold the result while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_key   <= w_key;
            r_mixed <= w_key ^ i_req.data_bit;
            r_sel   <= w_sel;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.key_bit       = r_key;
    assign o_rsp.mixed_bit     = r_mixed;
    assign o_rsp.register_bits = r_sel;
endmodule

### rtl/ftlk_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the keystream generator, bound to the top level.
// Depends on ftlk_pkg for the select width.
module ftlk_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_req_valid,
    input logic                         i_req_ready,
    input logic                         i_req_data_bit,
    input logic                         i_rsp_valid,
    input logic                         i_rsp_ready,
    input logic                         i_rsp_key_bit,
    input logic                         i_rsp_mixed_bit,
    input logic [ftlk_pkg::SEL_W-1:0]   i_rsp_register_bits
);
    // a result is held until taken
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=> (i_rsp_valid && $stable(i_rsp_key_bit)
            && $stable(i_rsp_mixed_bit) && $stable(i_rsp_register_bits)))
        else $error("ftlk: stalled result changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !i_rsp_valid)
        else $error("ftlk: result valid right after reset");

    // every accepted transaction yields its result in the next cycle, mixed with its data bit
    a_mix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=>
            (i_rsp_valid && (i_rsp_mixed_bit == (i_rsp_key_bit ^ $past(i_req_data_bit)))))
        else $error("ftlk: result missing or mixed bit wrong");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_rsp_valid |-> i_req_ready)
        else $error("ftlk: input stalled with empty output stage");

    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !$past(i_rsp_valid) && $past(i_rst_n)) |->
            $past(i_req_valid && i_req_ready))
        else $error("ftlk: result without transaction");
endmodule

bind filtered_three_lfsr_keystream ftlk_checker u_ftlk_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_req_valid         (i_req.valid),
    .i_req_ready         (i_req.ready),
    .i_req_data_bit      (i_req.data_bit),
    .i_rsp_valid         (o_rsp.valid),
    .i_rsp_ready         (o_rsp.ready),
    .i_rsp_key_bit       (o_rsp.key_bit),
    .i_rsp_mixed_bit     (o_rsp.mixed_bit),
    .i_rsp_register_bits (o_rsp.register_bits)
);
